### sv/pcbd_pkg.sv
`timescale 1ns / 1ps
// Package for the pulse cycle bit decoder: widths, register map, reset values,
// configuration and result structs, mask helpers. No dependencies.
package pcbd_pkg;

   localparam int MAX_BITS      = 64;
   localparam int COUNT_W       = 7;
   localparam int PULSE_W       = 16;
   localparam int PERIOD_W      = 16;
   localparam int PERIODS_W     = 4;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int SUM_W         = PULSE_W + 1;
   localparam int EXPECT_W      = PERIOD_W + PERIODS_W + 1;
   localparam int CMP_W         = EXPECT_W + 1;

   localparam logic [PERIOD_W-1:0]  PERIOD_RST = 16'd350;
   localparam logic [PERIODS_W-1:0] SHORT_RST  = 4'd1;
   localparam logic [PERIODS_W-1:0] LONG_RST   = 4'd3;
   localparam logic [COUNT_W-1:0]   FRAME_RST  = 7'd24;

   typedef enum logic [1:0] {
      REG_PERIOD = 2'd0,
      REG_SHORT  = 2'd1,
      REG_LONG   = 2'd2,
      REG_FRAME  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]  period_us;
      logic [PERIODS_W-1:0] short_periods;
      logic [PERIODS_W-1:0] long_periods;
      logic [COUNT_W-1:0]   frame_length;
   } cfg_type;

   typedef struct packed {
      logic                emit;
      logic [MAX_BITS-1:0] frame_bits;
      logic [COUNT_W-1:0]  bit_count;
   } result_type;

   function automatic logic [MAX_BITS-1:0] low_mask(input logic [COUNT_W-1:0] n);
      logic [MAX_BITS-1:0] m;
      for (int i = 0; i < MAX_BITS; i++) begin
         m[i] = (COUNT_W'(i) < n);
      end
      return m;
   endfunction

   function automatic logic [COUNT_W-1:0] kept_length(input logic [COUNT_W-1:0] len);
      logic [COUNT_W-1:0] r;
      r = len;
      if (len == '0) begin
         r = COUNT_W'(1);
      end else if (len > COUNT_W'(MAX_BITS)) begin
         r = COUNT_W'(MAX_BITS);
      end
      return r;
   endfunction

endpackage

### sv/pcbd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pulse transactions and frame transactions.
// Depends on pcbd_pkg.
interface pcbd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         level;
   logic [pcbd_pkg::PULSE_W-1:0] pulse_us;

   modport source (output valid, output level, output pulse_us, input ready);
   modport sink (input valid, input level, input pulse_us, output ready);
endinterface

interface pcbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcbd_pkg::MAX_BITS-1:0] frame_bits;
   logic [pcbd_pkg::COUNT_W-1:0]  bit_count;

   modport source (output valid, output frame_bits, output bit_count, input ready);
   modport sink (input valid, input frame_bits, input bit_count, output ready);
endinterface

### sv/pcbd_core.sv
`timescale 1ns / 1ps
// Decode datapath: frame state, timing window check and bit shifter.
// Depends on pcbd_pkg.
module pcbd_core (
   input  logic                         clock,
   input  logic                         reset,
   input  pcbd_pkg::cfg_type            cfg,
   input  logic                         fire,
   input  logic                         level,
   input  logic [pcbd_pkg::PULSE_W-1:0] pulse_us,
   output pcbd_pkg::result_type         result
);

   logic [pcbd_pkg::PULSE_W-1:0]  high_time_ff, high_time_in;
   logic [pcbd_pkg::MAX_BITS-1:0] bit_shift_ff, bit_shift_in;
   logic [pcbd_pkg::COUNT_W-1:0]  bit_position_ff, bit_position_in;

   logic [pcbd_pkg::SUM_W-1:0]      sum;
   logic [pcbd_pkg::PERIODS_W:0]    periods;
   logic [pcbd_pkg::EXPECT_W-1:0]   expected;
   logic [pcbd_pkg::PERIOD_W-2:0]   tol;
   logic                            in_window;
   logic                            bit_val;
   logic [pcbd_pkg::COUNT_W-1:0]    len;
   logic [pcbd_pkg::COUNT_W-1:0]    pos_inc;
   logic [pcbd_pkg::COUNT_W-1:0]    npos;

   always_comb begin
      sum      = pcbd_pkg::SUM_W'(pulse_us) + pcbd_pkg::SUM_W'(high_time_ff);
      periods  = (pcbd_pkg::PERIODS_W+1)'(cfg.short_periods)
               + (pcbd_pkg::PERIODS_W+1)'(cfg.long_periods);
      expected = pcbd_pkg::EXPECT_W'(periods) * pcbd_pkg::EXPECT_W'(cfg.period_us);
      tol      = cfg.period_us[pcbd_pkg::PERIOD_W-1:1];
      in_window = ((pcbd_pkg::CMP_W'(sum) + pcbd_pkg::CMP_W'(tol))
                   >= pcbd_pkg::CMP_W'(expected))
               && (pcbd_pkg::CMP_W'(sum)
                   <= (pcbd_pkg::CMP_W'(expected) + pcbd_pkg::CMP_W'(tol)));
      bit_val  = high_time_ff > pulse_us;
      len      = pcbd_pkg::kept_length(cfg.frame_length);
      pos_inc  = bit_position_ff + pcbd_pkg::COUNT_W'(1);
      npos     = (pos_inc > len) ? len : pos_inc;

      high_time_in    = high_time_ff;
      bit_shift_in    = bit_shift_ff;
      bit_position_in = bit_position_ff;
      if (fire) begin
         if (level) begin
            high_time_in = pulse_us;
         end else if (in_window) begin
            bit_shift_in    = {bit_shift_ff[pcbd_pkg::MAX_BITS-2:0], bit_val}
                            & pcbd_pkg::low_mask(npos);
            bit_position_in = npos;
         end else begin
            bit_shift_in    = '0;
            bit_position_in = '0;
         end
      end

      // stored bits above the count are always zero
      result.emit       = !level && !in_window;
      result.frame_bits = bit_shift_ff;
      result.bit_count  = bit_position_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_time_ff    <= '0;
         bit_shift_ff    <= '0;
         bit_position_ff <= '0;
      end else begin
         high_time_ff    <= high_time_in;
         bit_shift_ff    <= bit_shift_in;
         bit_position_ff <= bit_position_in;
      end
   end

endmodule

### sv/pulse_cycle_bit_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the pulse cycle bit decoder: CSR block, input and output registers.
// Depends on pcbd_pkg, pcbd_if.sv and pcbd_core.
//
// Usage:
//   req_ch carries one measured pulse per transaction (level, pulse_us).
//   rsp_ch carries one frame transaction (frame_bits, bit_count) each time a
//   low pulse closes a high/low pair that falls outside the timing window.
//   csr_* is an APB-style port: period_us at 0x0, short_periods at 0x4,
//   long_periods at 0x8, frame_length at 0xC. Write only while idle.
// Path: an accepted pulse waits in the input register and is decoded from there;
//   a frame it ends goes to the output register, which drives rsp_ch.
// Throughput: one pulse per cycle, limited by the single input register feeding
//   the decode stage, unless a frame-ending pulse waits on a full output register.
// Stall: with rsp_ch stalled and a frame held, pulses that emit nothing still
//   flow; the next frame-ending pulse waits in the input register, and
//   req_ch.ready drops once that register is full.
// Reset: synchronous; clears frame state, stored high time and the valid flags of
//   both channel registers, and loads the register defaults (350, 1, 3, 24).
module pulse_cycle_bit_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   pcbd_req_if.sink                        req_ch,
   pcbd_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pcbd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pcbd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pcbd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   pcbd_pkg::cfg_type cfg_ff, cfg_in;
   pcbd_pkg::reg_index_type csr_index;
   logic csr_write;

   logic                         in_valid_ff, in_valid_in;
   logic                         in_level_ff, in_level_in;
   logic [pcbd_pkg::PULSE_W-1:0] in_pulse_ff, in_pulse_in;

   logic                          out_valid_ff, out_valid_in;
   logic [pcbd_pkg::MAX_BITS-1:0] out_bits_ff, out_bits_in;
   logic [pcbd_pkg::COUNT_W-1:0]  out_count_ff, out_count_in;

   pcbd_pkg::result_type result;
   logic out_load_ok;
   logic stage_fire;
   logic req_take;

   // configuration registers
   always_comb begin
      csr_index  = pcbd_pkg::reg_index_type'(csr_paddr[3:2]);
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      csr_pready = 1'b1;
      cfg_in     = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            pcbd_pkg::REG_PERIOD: cfg_in.period_us     = csr_pwdata[pcbd_pkg::PERIOD_W-1:0];
            pcbd_pkg::REG_SHORT:  cfg_in.short_periods = csr_pwdata[pcbd_pkg::PERIODS_W-1:0];
            pcbd_pkg::REG_LONG:   cfg_in.long_periods  = csr_pwdata[pcbd_pkg::PERIODS_W-1:0];
            pcbd_pkg::REG_FRAME:  cfg_in.frame_length  = csr_pwdata[pcbd_pkg::COUNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
      case (csr_index)
         pcbd_pkg::REG_PERIOD: csr_prdata = pcbd_pkg::CSR_DATA_W'(cfg_ff.period_us);
         pcbd_pkg::REG_SHORT:  csr_prdata = pcbd_pkg::CSR_DATA_W'(cfg_ff.short_periods);
         pcbd_pkg::REG_LONG:   csr_prdata = pcbd_pkg::CSR_DATA_W'(cfg_ff.long_periods);
         pcbd_pkg::REG_FRAME:  csr_prdata = pcbd_pkg::CSR_DATA_W'(cfg_ff.frame_length);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_us     <= pcbd_pkg::PERIOD_RST;
         cfg_ff.short_periods <= pcbd_pkg::SHORT_RST;
         cfg_ff.long_periods  <= pcbd_pkg::LONG_RST;
         cfg_ff.frame_length  <= pcbd_pkg::FRAME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcbd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .fire     (stage_fire),
      .level    (in_level_ff),
      .pulse_us (in_pulse_ff),
      .result   (result)
   );

   // handshake and channel registers
   always_comb begin
      out_load_ok  = !out_valid_ff || rsp_ch.ready;
      stage_fire   = in_valid_ff && (!result.emit || out_load_ok);
      req_ch.ready = !in_valid_ff || stage_fire;
      req_take     = req_ch.valid && req_ch.ready;

      in_valid_in = in_valid_ff;
      in_level_in = in_level_ff;
      in_pulse_in = in_pulse_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_level_in = req_ch.level;
         in_pulse_in = req_ch.pulse_us;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_bits_in  = out_bits_ff;
      out_count_in = out_count_ff;
      if (stage_fire && result.emit) begin
         out_valid_in = 1'b1;
         out_bits_in  = result.frame_bits;
         out_count_in = result.bit_count;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      rsp_ch.valid      = out_valid_ff;
      rsp_ch.frame_bits = out_bits_ff;
      rsp_ch.bit_count  = out_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_level_ff  <= in_level_in;
      in_pulse_ff  <= in_pulse_in;
      out_bits_ff  <= out_bits_in;
      out_count_ff <= out_count_in;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_count_ff <= pcbd_pkg::COUNT_W'(pcbd_pkg::MAX_BITS)))
      else $error("frame count above maximum");

   a_bits_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_bits_ff & ~pcbd_pkg::low_mask(out_count_ff)) == '0))
      else $error("frame bits set above count");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && result.emit) |=> out_valid_ff)
      else $error("frame transaction lost");

   a_pulse_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !stage_fire) |=> (in_valid_ff && $stable(in_pulse_ff)))
      else $error("pending pulse dropped");

endmodule

### dv/pcbd_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the pulse cycle bit decoder bench: tracks register settings and
// frame state per accepted pulse and checks frame transactions. Depends on pcbd_pkg.
package pcbd_tb_pkg;
   import pcbd_pkg::*;

   typedef struct {
      logic [MAX_BITS-1:0] frame_bits;
      logic [COUNT_W-1:0]  bit_count;
   } frame_rec_type;

   class frame_scoreboard;
      logic [PERIOD_W-1:0]  period_us;
      logic [PERIODS_W-1:0] short_periods;
      logic [PERIODS_W-1:0] long_periods;
      logic [COUNT_W-1:0]   frame_length;
      logic [PULSE_W-1:0]   high_time;
      logic [MAX_BITS-1:0]  shift_bits;
      logic [COUNT_W-1:0]   bit_count;
      frame_rec_type        awaited_frames[$];
      int unsigned          fails;

      function new();
         period_us     = PERIOD_RST;
         short_periods = SHORT_RST;
         long_periods  = LONG_RST;
         frame_length  = FRAME_RST;
         high_time     = '0;
         shift_bits    = '0;
         bit_count     = '0;
         fails         = 0;
      endfunction

      function logic [MAX_BITS-1:0] valid_bits_mask(input logic [COUNT_W-1:0] n);
         return (n >= COUNT_W'(MAX_BITS)) ? '1 : ((MAX_BITS'(1) << n) - MAX_BITS'(1));
      endfunction

      function void write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_PERIOD: period_us     = value[PERIOD_W-1:0];
            REG_SHORT:  short_periods = value[PERIODS_W-1:0];
            REG_LONG:   long_periods  = value[PERIODS_W-1:0];
            REG_FRAME:  frame_length  = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pulse(input logic level, input logic [PULSE_W-1:0] pulse_us);
         int unsigned        total;
         int unsigned        target;
         int unsigned        tol;
         logic [COUNT_W-1:0] keep;
         logic [COUNT_W-1:0] next_count;
         frame_rec_type      rec;
         if (level) begin
            high_time = pulse_us;
            return;
         end
         total  = 32'(pulse_us) + 32'(high_time);
         target = (32'(short_periods) + 32'(long_periods)) * 32'(period_us);
         tol    = 32'(period_us) / 2;
         if (total + tol >= target && total <= target + tol) begin
            keep = frame_length;
            if (keep == '0) begin
               keep = COUNT_W'(1);
            end else if (keep > COUNT_W'(MAX_BITS)) begin
               keep = COUNT_W'(MAX_BITS);
            end
            next_count = bit_count + COUNT_W'(1);
            if (next_count > keep) begin
               next_count = keep;
            end
            shift_bits = ((shift_bits << 1) | MAX_BITS'(high_time > pulse_us))
                         & valid_bits_mask(next_count);
            bit_count  = next_count;
         end else begin
            rec.frame_bits = shift_bits & valid_bits_mask(bit_count);
            rec.bit_count  = bit_count;
            awaited_frames.push_back(rec);
            shift_bits = '0;
            bit_count  = '0;
         end
      endfunction

      function void check_frame(input logic [MAX_BITS-1:0] bits,
                                input logic [COUNT_W-1:0] count);
         frame_rec_type want;
         if (awaited_frames.size() == 0) begin
            $error("unexpected frame transaction: frame_bits %h bit_count %0d", bits, count);
            fails++;
            return;
         end
         want = awaited_frames.pop_front();
         if (bits !== want.frame_bits) begin
            $error("frame_bits expected %h actual %h", want.frame_bits, bits);
            fails++;
         end
         if (count !== want.bit_count) begin
            $error("bit_count expected %0d actual %0d", want.bit_count, count);
            fails++;
         end
      endfunction

      function int pending();
         return awaited_frames.size();
      endfunction
   endclass

endpackage

### dv/pulse_cycle_bit_decoder_top_tb.sv
`timescale 1ns / 1ps
// Bench for pulse_cycle_bit_decoder_top: directed and random pulse streams over
// several register settings, checked by frame_scoreboard. Depends on pcbd_pkg,
// pcbd_if.sv, pcbd_tb_pkg and the decoder RTL.
module pulse_cycle_bit_decoder_top_tb;
   import pcbd_pkg::*;
   import pcbd_tb_pkg::*;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          SETTLE_CYCLES = 6;
   localparam int unsigned SUM_MAX       = 2 * 65535;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int              sender_idle   = 31;
   int              receiver_idle = 67;
   bit              hold_request  = 1'b0;
   int              items_sent    = 0;
   int              cycle_count   = 0;
   frame_scoreboard sb;

   pcbd_req_if req_ch ();
   pcbd_rsp_if rsp_ch ();

   pulse_cycle_bit_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_pulse(req_ch.level, req_ch.pulse_us);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_frame(rsp_ch.frame_bits, rsp_ch.bit_count);
         end
      end
   end

   initial begin : rsp_ready_drive
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= receiver_idle);
         end
      end
   end

   task automatic send_pulse(input logic level, input logic [PULSE_W-1:0] pulse);
      while ($urandom_range(99, 0) < sender_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.level    <= level;
      req_ch.pulse_us <= pulse;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] period,
                             input logic [CSR_DATA_W-1:0] short_n,
                             input logic [CSR_DATA_W-1:0] long_n,
                             input logic [CSR_DATA_W-1:0] frame_len);
      csr_write(REG_PERIOD, period);
      csr_write(REG_SHORT, short_n);
      csr_write(REG_LONG, long_n);
      csr_write(REG_FRAME, frame_len);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // all frames delivered, then let in-flight pulses that emit nothing settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void window_bounds(output int unsigned lo, output int unsigned hi);
      int unsigned target;
      int unsigned tol;
      target = (32'(sb.short_periods) + 32'(sb.long_periods)) * 32'(sb.period_us);
      tol    = 32'(sb.period_us) / 2;
      lo     = (target > tol) ? target - tol : 0;
      hi     = target + tol;
   endfunction

   task automatic send_noise();
      send_pulse(1'(($urandom_range(1, 0))), 16'($urandom_range(65535, 0)));
   endtask

   task automatic send_split(input int unsigned total);
      int unsigned h;
      h = $urandom_range(total > 65535 ? total - 65535 : 0, total < 65535 ? total : 65535);
      if ($urandom_range(7, 0) == 0 && total % 2 == 0) begin
         h = total / 2;
      end
      send_pulse(1'b1, 16'(h));
      send_pulse(1'b0, 16'(total - h));
   endtask

   task automatic send_good_pair();
      int unsigned lo;
      int unsigned hi;
      int unsigned total;
      window_bounds(lo, hi);
      if (hi > SUM_MAX) begin
         hi = SUM_MAX;
      end
      if (lo > hi) begin
         send_noise();
         return;
      end
      case ($urandom_range(9, 0))
         0: total = lo;
         1: total = hi;
         default: total = $urandom_range(hi, lo);
      endcase
      send_split(total);
   endtask

   task automatic send_frame_end();
      int unsigned lo;
      int unsigned hi;
      int unsigned total;
      window_bounds(lo, hi);
      if ($urandom_range(3, 0) == 0) begin
         send_pulse(1'b0, 16'($urandom_range(65535, 0)));
         return;
      end
      if (lo > 0 && ($urandom_range(1, 0) == 0 || hi >= SUM_MAX)) begin
         total = $urandom_range(1, 0) ? lo - 1 : $urandom_range(lo - 1, 0);
         if (total > SUM_MAX) begin
            total = SUM_MAX;
         end
      end else begin
         total = $urandom_range(1, 0) ? hi + 1 : $urandom_range(SUM_MAX, hi + 1);
      end
      send_split(total);
   endtask

   task automatic send_frame();
      int nbits;
      nbits = ($urandom_range(7, 0) == 0) ? $urandom_range(70, 0) : $urandom_range(12, 0);
      repeat (nbits) begin
         if ($urandom_range(99, 0) < 88) begin
            send_good_pair();
         end else begin
            send_noise();
         end
      end
      send_frame_end();
   endtask

   initial begin
      int goal;
      sb              = new();
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.level    = 1'b0;
      req_ch.pulse_us = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: window 1225..1575
      send_pulse(1'b0, 16'd0);
      send_pulse(1'b1, 16'd1050);
      send_pulse(1'b0, 16'd350);
      send_pulse(1'b1, 16'd350);
      send_pulse(1'b0, 16'd1050);
      send_pulse(1'b1, 16'd700);
      send_pulse(1'b0, 16'd700);
      send_pulse(1'b1, 16'd1000);
      send_pulse(1'b0, 16'd225);
      send_pulse(1'b1, 16'd1000);
      send_pulse(1'b0, 16'd575);
      wait_drained();
      // frame shortened while bits are held
      set_config(350, 1, 3, 2);
      send_pulse(1'b1, 16'd1050);
      send_pulse(1'b0, 16'd350);
      send_pulse(1'b0, 16'd576);
      send_pulse(1'b0, 16'd576);
      send_pulse(1'b1, 16'hFFFF);
      send_pulse(1'b0, 16'hFFFF);
      send_pulse(1'b1, 16'd0);
      send_pulse(1'b0, 16'd1224);
      wait_drained();
      // zero counts, zero tolerance, frame length zero
      set_config(1, 0, 0, 0);
      send_pulse(1'b1, 16'd0);
      send_pulse(1'b0, 16'd0);
      send_pulse(1'b1, 16'd1);
      send_pulse(1'b0, 16'd0);
      wait_drained();
      set_config(16'hFFFF, 15, 15, 127);
      send_pulse(1'b1, 16'hFFFF);
      send_pulse(1'b0, 16'hFFFF);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               sender_idle   = 31;
               receiver_idle = 67;
            end
            1: begin
               sender_idle   = 67;
               receiver_idle = 31;
            end
            default: begin
               sender_idle   = 0;
               receiver_idle = 0;
            end
         endcase
         case (phase)
            0: set_config($urandom_range(1000, 100), $urandom_range(4, 1),
                          $urandom_range(15, 3), $urandom_range(64, 1));
            1: set_config(16'hFFFF, 1, 1, 64);
            2: set_config(4000, 15, 15, 1);
            3: set_config($urandom_range(3000, 1), $urandom_range(15, 0),
                          $urandom_range(15, 0), $urandom_range(127, 0));
            4: set_config(1, 15, 15, 65);
            default: set_config($urandom_range(500, 2), $urandom_range(8, 1),
                                $urandom_range(8, 1), $urandom_range(40, 8));
         endcase
         if (phase == 1) begin
            hold_request = 1'b1;
         end
         goal = items_sent + 95;
         while (items_sent < goal) begin
            send_frame();
         end
         // leave a partial frame across the register change
         repeat ($urandom_range(20, 0)) send_good_pair();
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
